[hdl/lzwd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW variant decoder package
// Shared constants, types and state codes.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int DictDepthDefault  = 4096;
  localparam int StackDepthDefault = 4096;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_POP  = 2'd1,
    PH_LIT  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_WALK = 2'd1,
    BK_SEND = 2'd2
  } bk_state_t;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       byte_taken;
    logic       need_input;
    logic       finished;
    logic       overflow;
  } result_t;

endpackage

[hdl/lzwd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW variant decoder front end
// Accepts input requests and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module lzwd_front import lzwd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte[7:0]
  input  logic        s_tuser,   // op
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);

  item_t       slot [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr].op      <= s_tuser;
      slot[wr_ptr].in_byte <= s_tdata;
    end
  end

endmodule

[hdl/lzwd_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW variant decoder engine
// Bit buffer, dictionary walk, suffix stack and output register.
// ----------------------------------------------------------------------------
module lzwd_engine import lzwd_pkg::*; #(
  parameter int DICT_DEPTH  = DictDepthDefault,
  parameter int STACK_DEPTH = StackDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata
);

  localparam int DW = $clog2(DICT_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH);

  logic [19:0] dict [DICT_DEPTH];
  logic [7:0]  stk  [STACK_DEPTH];
  logic [DW:0] clr_addr;
  logic        clearing;

  bk_state_t   state, state_next;
  logic [2:0]  header_bytes_seen;
  logic [31:0] output_length;
  logic [31:0] bytes_emitted;
  phase_t      phase;
  logic [3:0]  code_width;
  logic [11:0] next_entry;
  logic [11:0] entry_limit;
  logic [11:0] last_code;
  logic [23:0] bit_buffer;
  logic [4:0]  bit_count;
  logic [SW:0] stack_pointer;
  logic        error_seen;
  logic [11:0] cur;
  logic [19:0] dict_q;
  logic [7:0]  stk_q;
  logic        pop_pending;
  result_t     res;
  logic        out_full;

  logic        hdr_done;
  logic [4:0]  rest_code;
  logic [4:0]  rest_lit;
  logic [11:0] code_bits;
  logic [7:0]  lit_bits;
  logic [11:0] pre;
  logic [11:0] ne_inc;
  logic [3:0]  cw_inc;
  logic        start;
  logic        finished_now;

  assign hdr_done  = (header_bytes_seen == 3'd4);
  assign rest_code = bit_count - {1'b0, code_width};
  assign rest_lit  = bit_count - 5'd8;
  assign code_bits = 12'((bit_buffer >> rest_code) & ((24'd1 << code_width) - 24'd1));
  assign lit_bits  = 8'(bit_buffer >> rest_lit);
  assign pre       = ({1'b0, last_code} >= 13'h100 + {1'b0, next_entry}) ? 12'h100 : last_code;
  assign ne_inc    = next_entry + 12'd1;
  assign cw_inc    = code_width + 4'd1;
  assign clearing  = (clr_addr != DICT_DEPTH[DW:0]);
  assign q_ready   = (state == BK_IDLE) && !out_full && !pop_pending && !clearing;
  assign start     = q_valid && q_ready;
  assign m_tvalid  = out_full;
  assign m_tdata   = {3'd0, res.overflow, res.finished, res.need_input, res.byte_taken,
                      res.out_valid, res.out_byte};

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (start && q_item.op == OP_PULL && !error_seen && hdr_done
                   && bytes_emitted < output_length && phase == PH_CODE
                   && bit_count >= {1'b0, code_width} && code_bits >= 12'd256)
        state_next = BK_WALK;
      BK_WALK: if (cur < 12'd256 || stack_pointer == STACK_DEPTH[SW:0]) state_next = BK_SEND;
      BK_SEND: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Dictionary read address follows the chain; read data is registered.
  always_ff @(posedge clk) begin
    if (clearing) dict[clr_addr[DW-1:0]] <= 20'd0;
    else if (start && q_item.op == OP_PULL && !error_seen && hdr_done
             && bytes_emitted < output_length && phase == PH_LIT && bit_count >= 5'd8)
      dict[DW'(next_entry)] <= {pre, lit_bits};
    dict_q <= dict[DW'(state == BK_WALK ? 12'(dict_q[19:8] - 12'd256)
                                        : 12'(code_bits - 12'd256))];
  end

  always_ff @(posedge clk) begin
    if (state == BK_WALK && cur >= 12'd256 && stack_pointer != STACK_DEPTH[SW:0])
      stk[stack_pointer[SW-1:0]] <= dict_q[7:0];
    stk_q <= stk[SW'(stack_pointer - 1'b1)];
  end

  assign finished_now = hdr_done && (bytes_emitted >= output_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      state <= BK_IDLE;
      header_bytes_seen <= 3'd0;
      output_length <= 32'd4;
      bytes_emitted <= 32'd0;
      phase <= PH_CODE;
      code_width <= 4'd9;
      next_entry <= 12'd0;
      entry_limit <= 12'd255;
      last_code <= 12'd0;
      bit_buffer <= 24'd0;
      bit_count <= 5'd0;
      stack_pointer <= '0;
      error_seen <= 1'b0;
      out_full <= 1'b0;
      pop_pending <= 1'b0;
      cur <= 12'd0;
      res <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_addr <= clr_addr + 1'b1;
      if (m_tvalid && m_tready) out_full <= 1'b0;
      if (pop_pending) begin
        pop_pending <= 1'b0;
        res.out_byte <= stk_q;
        out_full <= 1'b1;
      end
      if (state == BK_WALK) begin
        if (cur < 12'd256) begin
          res.out_byte <= cur[7:0];
          res.out_valid <= 1'b1;
          bytes_emitted <= bytes_emitted + 32'd1;
          phase <= (stack_pointer != '0) ? PH_POP : PH_LIT;
          res.finished <= hdr_done && (bytes_emitted + 32'd1 >= output_length);
          res.overflow <= 1'b0;
        end else if (stack_pointer == STACK_DEPTH[SW:0]) begin
          error_seen <= 1'b1;
          stack_pointer <= '0;
          res.out_byte <= 8'd0;
          res.out_valid <= 1'b0;
          res.finished <= finished_now;
          res.overflow <= 1'b1;
        end else begin
          stack_pointer <= stack_pointer + 1'b1;
          cur <= dict_q[19:8];
        end
      end
      if (state == BK_SEND) out_full <= 1'b1;
      if (start) begin
        res <= '0;
        res.overflow <= error_seen;
        if (q_item.op == OP_FEED) begin
          if (!error_seen) begin
            if (!hdr_done) begin
              case (header_bytes_seen)
                3'd0: output_length <= {24'd0, q_item.in_byte};
                3'd1: output_length[15:8] <= q_item.in_byte;
                3'd2: output_length[23:16] <= q_item.in_byte;
                default: output_length[31:24] <= q_item.in_byte;
              endcase
              header_bytes_seen <= header_bytes_seen + 3'd1;
              res.byte_taken <= 1'b1;
              res.finished <= (header_bytes_seen == 3'd3) &&
                (bytes_emitted >= {q_item.in_byte, output_length[23:0]});
            end else begin
              res.finished <= finished_now;
              if (bit_count <= 5'd16) begin
                bit_buffer <= {bit_buffer[15:0], q_item.in_byte};
                bit_count <= bit_count + 5'd8;
                res.byte_taken <= 1'b1;
              end
            end
          end else res.finished <= finished_now;
          out_full <= 1'b1;
        end else if (error_seen) begin
          res.finished <= finished_now;
          out_full <= 1'b1;
        end else if (!hdr_done) begin
          res.need_input <= 1'b1;
          out_full <= 1'b1;
        end else if (bytes_emitted >= output_length) begin
          res.finished <= 1'b1;
          out_full <= 1'b1;
        end else begin
          case (phase)
            PH_POP: begin
              if (stack_pointer != '0) begin
                stack_pointer <= stack_pointer - 1'b1;
                res.out_valid <= 1'b1;
                bytes_emitted <= bytes_emitted + 32'd1;
                res.finished <= (bytes_emitted + 32'd1 >= output_length);
                pop_pending <= 1'b1;
              end else out_full <= 1'b1;
              if (stack_pointer <= {{SW{1'b0}}, 1'b1}) phase <= PH_LIT;
            end
            PH_LIT: begin
              out_full <= 1'b1;
              if (bit_count < 5'd8) res.need_input <= 1'b1;
              else begin
                res.out_byte <= lit_bits;
                res.out_valid <= 1'b1;
                bytes_emitted <= bytes_emitted + 32'd1;
                res.finished <= (bytes_emitted + 32'd1 >= output_length);
                bit_count <= rest_lit;
                bit_buffer <= bit_buffer & ((24'd1 << rest_lit) - 24'd1);
                phase <= PH_CODE;
                next_entry <= ne_inc;
                if (ne_inc >= entry_limit) begin
                  code_width <= cw_inc;
                  if (cw_inc == 4'd13) begin
                    code_width <= 4'd9;
                    next_entry <= 12'd64;
                    entry_limit <= 12'd255;
                  end else entry_limit <= 12'((13'd1 << cw_inc) - 13'd257);
                end
              end
            end
            default: begin
              if (bit_count < {1'b0, code_width}) begin
                res.need_input <= 1'b1;
                out_full <= 1'b1;
              end else begin
                bit_count <= rest_code;
                bit_buffer <= bit_buffer & ((24'd1 << rest_code) - 24'd1);
                last_code <= code_bits;
                cur <= code_bits;
                if (code_bits < 12'd256) begin
                  res.out_byte <= code_bits[7:0];
                  res.out_valid <= 1'b1;
                  bytes_emitted <= bytes_emitted + 32'd1;
                  res.finished <= (bytes_emitted + 32'd1 >= output_length);
                  phase <= (stack_pointer != '0) ? PH_POP : PH_LIT;
                  out_full <= 1'b1;
                end
              end
            end
          endcase
        end
      end
    end
  end

endmodule

[hdl/lzw_variant_decompressor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW variant decompressor
// Request/response decoder for 9 to 12 bit LZW codes alternating with literals.
// ----------------------------------------------------------------------------
// Each request on the s_axis channel either feeds one compressed byte (op 0)
// or pulls one decompressed byte (op 1); every request yields exactly one
// response on m_axis carrying the byte and status flags.
// Requests enter a two-entry queue so the sender can run ahead while the
// engine works. A pull that fetches a code walks the prefix chain in the
// dictionary at one entry per cycle; a stack pop goes through the registered
// stack read. After reset every dictionary entry is cleared, and meanwhile no
// request is taken from the queue. If the receiver stalls, the response stays
// in the output register and the queue fills, then s_tready falls.
// ----------------------------------------------------------------------------
module lzw_variant_decompressor import lzwd_pkg::*; #(
  parameter int DICT_DEPTH  = DictDepthDefault,
  parameter int STACK_DEPTH = StackDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // in_byte[7:0]
  input  logic        s_tuser,  // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // out_byte, out_valid, byte_taken, need_input,
                                // finished, overflow
);

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  lzwd_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .q_valid(q_valid), .q_ready(q_ready),
    .q_item(q_item)
  );

  lzwd_engine #(.DICT_DEPTH(DICT_DEPTH), .STACK_DEPTH(STACK_DEPTH)) u_engine (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule

[sim/lzw_variant_decompressor_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW variant decompressor testbench
// Builds one well-formed compressed stream of literal codes, dictionary codes
// and an undefined code, then drives it as feed and pull requests with random
// bursts, gaps and receiver stalls. Every response is checked against a
// cycle-free model of the decoder.
// ----------------------------------------------------------------------------
module lzw_variant_decompressor_test;
  import lzwd_pkg::*;

  class lzw_decoder_model;
    logic [2:0]  hdr_seen;
    logic [31:0] out_len;
    logic [31:0] emitted;
    phase_t      ph;
    int unsigned width;
    int unsigned next_idx;
    int unsigned limit;
    int unsigned prev_code;
    logic [23:0] bitbuf;
    int unsigned nbits;
    logic [19:0] dict [DictDepthDefault];
    logic [7:0]  stk [StackDepthDefault];
    int unsigned sp;
    bit          err;

    function new();
      hdr_seen = 0;
      out_len = 4;
      emitted = 0;
      ph = PH_CODE;
      width = 9;
      next_idx = 0;
      limit = 255;
      prev_code = 0;
      bitbuf = 0;
      nbits = 0;
      foreach (dict[i]) dict[i] = '0;
      sp = 0;
      err = 0;
    endfunction

    function int unsigned grab(int unsigned n);
      int unsigned rest;
      int unsigned v;
      rest = nbits - n;
      v = (bitbuf >> rest) & ((1 << n) - 1);
      nbits = rest;
      bitbuf = 24'(bitbuf & ((24'd1 << rest) - 24'd1));
      return v;
    endfunction

    function void add_entry(logic [7:0] lit);
      int unsigned pre;
      pre = prev_code & 12'hFFF;
      // A prefix naming a code that does not exist yet is stored as 0x100.
      if (pre >= 256 + next_idx) pre = 256;
      dict[next_idx % DictDepthDefault] = {pre[11:0], lit};
      next_idx = (next_idx + 1) & 12'hFFF;
      if (next_idx >= limit) begin
        width++;
        if (width == 13) begin
          width = 9;
          next_idx = 64;
          limit = 255;
        end else begin
          limit = ((1 << width) - 257) & 12'hFFF;
        end
      end
    endfunction

    function result_t step(logic op, logic [7:0] in_byte);
      result_t r;
      int unsigned cur;
      logic [19:0] ent;
      r = '0;
      if (op == OP_FEED) begin
        if (err) begin
          r.byte_taken = 0;
        end else if (hdr_seen < 4) begin
          if (hdr_seen == 0) out_len = 32'(in_byte);
          else out_len = out_len | (32'(in_byte) << (8 * hdr_seen));
          hdr_seen++;
          r.byte_taken = 1;
        end else if (nbits <= 16) begin
          bitbuf = {bitbuf[15:0], in_byte};
          nbits += 8;
          r.byte_taken = 1;
        end
      end else if (err) begin
      end else if (hdr_seen < 4) begin
        r.need_input = 1;
      end else if (emitted < out_len) begin
        if (ph == PH_POP) begin
          if (sp > 0) begin
            sp--;
            r.out_byte = stk[sp % StackDepthDefault];
            r.out_valid = 1;
          end
          if (sp == 0) ph = PH_LIT;
        end else if (ph == PH_LIT) begin
          if (nbits < 8) begin
            r.need_input = 1;
          end else begin
            r.out_byte = 8'(grab(8));
            r.out_valid = 1;
            add_entry(r.out_byte);
            ph = PH_CODE;
          end
        end else begin
          if (nbits < width) begin
            r.need_input = 1;
          end else begin
            cur = grab(width);
            prev_code = cur;
            while (cur >= 256 && !err) begin
              ent = dict[(cur - 256) % DictDepthDefault];
              if (sp >= StackDepthDefault) begin
                err = 1;
                sp = 0;
              end else begin
                stk[sp] = ent[7:0];
                sp++;
                cur = ent[19:8];
              end
            end
            if (!err) begin
              r.out_byte = cur[7:0];
              r.out_valid = 1;
              ph = (sp > 0) ? PH_POP : PH_LIT;
            end
          end
        end
        if (r.out_valid) emitted++;
      end
      r.finished = (hdr_seen >= 4 && emitted >= out_len);
      r.overflow = err;
      return r;
    endfunction
  endclass

  class lzw_scoreboard;
    lzw_decoder_model decoder;
    result_t pending_q[$];
    int errors;

    function new();
      decoder = new();
      errors = 0;
    endfunction

    function result_t note_request(logic op, logic [7:0] in_byte);
      result_t r;
      r = decoder.step(op, in_byte);
      pending_q.insert(pending_q.size(), r);
      return r;
    endfunction

    function void check_response(logic [15:0] data);
      result_t want;
      result_t got;
      got = data[12:0];
      // Response layout from bit 0 up: out_byte, out_valid, byte_taken,
      // need_input, finished, overflow.
      got.out_byte   = data[7:0];
      got.out_valid  = data[8];
      got.byte_taken = data[9];
      got.need_input = data[10];
      got.finished   = data[11];
      got.overflow   = data[12];
      if (pending_q.size() == 0) begin
        $error("unexpected response %h", data);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte expected %h actual %h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.out_valid !== want.out_valid) begin
        $error("out_valid expected %b actual %b", want.out_valid, got.out_valid);
        errors++;
      end
      if (got.byte_taken !== want.byte_taken) begin
        $error("byte_taken expected %b actual %b", want.byte_taken, got.byte_taken);
        errors++;
      end
      if (got.need_input !== want.need_input) begin
        $error("need_input expected %b actual %b", want.need_input, got.need_input);
        errors++;
      end
      if (got.finished !== want.finished) begin
        $error("finished expected %b actual %b", want.finished, got.finished);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow expected %b actual %b", want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  localparam int IdleLimit = 40000;
  localparam int NumPairs  = 120;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;

  lzw_scoreboard sb = new();
  logic [7:0] stream_q[$];
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;

  lzw_variant_decompressor dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_response(m_tdata);
  end

  // Receiver stalls: long stretches always ready, others choppy.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(32, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_tready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("lzw_variant_decompressor test failed");
      $finish;
    end
  end

  task automatic send_request(input logic op, input logic [7:0] in_byte,
                              output result_t r);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= in_byte;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    r = sb.note_request(op, in_byte);
    burst_left--;
  endtask

  // Encoder side: alternating code and literal, with the code width tracked
  // exactly as the decoder grows and wraps it.
  task automatic build_stream();
    int unsigned nxt;
    int unsigned w;
    int unsigned lim;
    int unsigned code;
    int unsigned lit;
    int unsigned pick;
    logic bits[$];
    logic [7:0] b;
    nxt = 0;
    w = 9;
    lim = 255;
    for (int p = 0; p < NumPairs; p++) begin
      pick = $urandom_range(0, 99);
      if (p == 0) code = 0;
      else if (p == 1) code = 255;
      else if (p == 2) code = (1 << w) - 1;
      else if (pick < 60 || nxt == 0) code = $urandom_range(0, 255);
      else if (pick < 95) code = 256 + $urandom_range(0, nxt - 1);
      else code = $urandom_range(0, (1 << w) - 1);
      lit = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : $urandom_range(0, 255);
      for (int i = w - 1; i >= 0; i--) bits.insert(bits.size(), code[i]);
      for (int i = 7; i >= 0; i--) bits.insert(bits.size(), lit[i]);
      nxt = (nxt + 1) & 12'hFFF;
      if (nxt >= lim) begin
        w++;
        if (w == 13) begin
          w = 9;
          nxt = 64;
          lim = 255;
        end else begin
          lim = (1 << w) - 257;
        end
      end
    end
    while (bits.size() % 8 != 0) bits.insert(bits.size(), 1'b0);
    while (bits.size() > 0) begin
      for (int i = 7; i >= 0; i--) b[i] = bits.pop_front();
      stream_q.insert(stream_q.size(), b);
    end
  endtask

  // Decodes the whole stream offline to learn how many bytes it yields.
  function automatic int unsigned decoded_length();
    lzw_decoder_model m;
    result_t r;
    int unsigned idx;
    int unsigned cnt;
    m = new();
    cnt = 0;
    idx = 0;
    repeat (4) r = m.step(OP_FEED, 8'hFF);
    forever begin
      r = m.step(OP_PULL, 8'h00);
      if (r.out_valid) cnt++;
      else if (r.need_input && idx < stream_q.size()) r = m.step(OP_FEED, stream_q[idx++]);
      else break;
    end
    return cnt;
  endfunction

  initial begin
    result_t r;
    int unsigned idx;
    logic [31:0] total;
    build_stream();
    total = decoded_length() - $urandom_range(0, 5);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Pulls before the header is complete only ask for input.
    send_request(OP_PULL, 8'h00, r);
    send_request(OP_PULL, 8'hFF, r);
    for (int i = 0; i < 4; i++) send_request(OP_FEED, total[8*i +: 8], r);

    idx = 0;
    while (sb.decoder.emitted < sb.decoder.out_len) begin
      if (idx < stream_q.size() && $urandom_range(0, 2) != 0 &&
          (sb.decoder.nbits <= 16 || $urandom_range(0, 7) == 0)) begin
        send_request(OP_FEED, stream_q[idx], r);
        // A refused byte is sent again later.
        if (r.byte_taken) idx++;
      end else begin
        send_request(OP_PULL, 8'($urandom_range(0, 255)), r);
      end
    end

    // After the end of output, pulls give nothing and feeds only fill bits.
    repeat (20) send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), r);
    s_tvalid <= 1'b0;

    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("lzw_variant_decompressor test passed");
    end else begin
      $display("lzw_variant_decompressor test failed");
    end
    $finish;
  end

endmodule

[lzw_variant_decompressor.f]
hdl/lzwd_pkg.sv
hdl/lzwd_front.sv
hdl/lzwd_engine.sv
hdl/lzw_variant_decompressor.sv
sim/lzw_variant_decompressor_test.sv
